### sv/htr_pkg.sv
// ----------------------------------------------------------------------------
// htr_pkg
// Shared types, widths and helpers of the hierarchical tile rasterizer.
// ----------------------------------------------------------------------------
package htr_pkg;

  localparam int TILE_SIZE     = 16;
  localparam int SUBPIXEL_BITS = 4;

  localparam int BLOCKS_PER_SIDE = (TILE_SIZE + 3) / 4;
  localparam int BLK_W = (BLOCKS_PER_SIDE > 1) ? $clog2(BLOCKS_PER_SIDE) : 1;

  // Internal math runs at 2^UNIT_SH units per pixel so the half-pixel center is exact.
  localparam int UNIT_SH = SUBPIXEL_BITS + 1;
  localparam int UNIT    = 1 << UNIT_SH;

  localparam int COORD_W = 16;              // input vertex fields
  localparam int TILE_W  = 8;               // tile row and column fields
  localparam int XY_W    = 12;              // pixel positions inside the screen
  localparam int DIM_W   = 13;              // screen width and height registers
  localparam int COV_W   = 16;

  localparam int VX_W  = COORD_W + 1;       // doubled vertex
  localparam int BC_W  = VX_W + 1;          // edge coefficients B and C
  localparam int CRD_W = DIM_W + UNIT_SH + 1;
  localparam int D_W   = ((CRD_W > VX_W) ? CRD_W : VX_W) + 1;
  localparam int E_W   = D_W + BC_W + 1;    // edge function values

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

  // Per-triangle setup handed from the front end to the block walker.
  typedef struct packed {
    logic [2:0][BC_W-1:0] b;
    logic [2:0][BC_W-1:0] c;
    logic [2:0][E_W-1:0]  e;    // edge value at the tile origin corner
    logic [XY_W-1:0]      tx;
    logic [XY_W-1:0]      ty;
  } setup_t;

  function automatic logic signed [E_W-1:0] sx_e(input logic signed [BC_W-1:0] v);
    return E_W'(v);
  endfunction

  // Coefficient times the offset of pixel center idx from the block corner.
  function automatic logic signed [E_W-1:0] pix_off(input logic signed [BC_W-1:0] v,
                                                    input int idx);
    logic signed [E_W-1:0] k;
    k = $signed(E_W'(idx * UNIT + UNIT / 2));
    return sx_e(v) * k;
  endfunction

endpackage

### sv/htr_in_if.sv
// ----------------------------------------------------------------------------
// htr_in_if
// Triangle and tile input channel.
// ----------------------------------------------------------------------------
interface htr_in_if import htr_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] v1_x;
  logic signed [COORD_W-1:0] v1_y;
  logic signed [COORD_W-1:0] v2_x;
  logic signed [COORD_W-1:0] v2_y;
  logic signed [COORD_W-1:0] v3_x;
  logic signed [COORD_W-1:0] v3_y;
  logic [TILE_W-1:0]         tile_col;
  logic [TILE_W-1:0]         tile_row;

  modport source(output valid, v1_x, v1_y, v2_x, v2_y, v3_x, v3_y, tile_col, tile_row,
                 input ready);
  modport sink(input valid, v1_x, v1_y, v2_x, v2_y, v3_x, v3_y, tile_col, tile_row,
               output ready);
endinterface

### sv/htr_out_if.sv
// ----------------------------------------------------------------------------
// htr_out_if
// Covered block output channel.
// ----------------------------------------------------------------------------
interface htr_out_if import htr_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [XY_W-1:0]  block_x;
  logic [XY_W-1:0]  block_y;
  logic [COV_W-1:0] coverage;
  logic             last;

  modport source(output valid, block_x, block_y, coverage, last, input ready);
  modport sink(input valid, block_x, block_y, coverage, last, output ready);
endinterface

### sv/htr_cfg_if.sv
// ----------------------------------------------------------------------------
// htr_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface htr_cfg_if import htr_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### sv/htr_front.sv
// ----------------------------------------------------------------------------
// htr_front
// Triangle setup: edge coefficients and edge values at the tile origin.
// ----------------------------------------------------------------------------
module htr_front import htr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  htr_in_if.sink tri_in,
  output logic   push_valid,
  input  logic   push_ready,
  output setup_t push_data
);

  typedef enum logic [1:0] {F_IDLE, F_DIFF, F_MUL, F_PUSH} fstate_t;

  fstate_t state;

  logic signed [VX_W-1:0] vx [3];
  logic signed [VX_W-1:0] vy [3];
  logic [XY_W-1:0]        tx;
  logic [XY_W-1:0]        ty;
  logic signed [BC_W-1:0] b [3];
  logic signed [BC_W-1:0] c [3];
  logic signed [D_W-1:0]  dx [3];
  logic signed [D_W-1:0]  dy [3];
  logic signed [E_W-1:0]  prod_x [3];
  logic signed [E_W-1:0]  prod_y [3];

  logic signed [D_W-1:0] tx_u;
  logic signed [D_W-1:0] ty_u;

  assign tri_in.ready = (state == F_IDLE);
  assign push_valid   = (state == F_PUSH);

  assign tx_u = $signed(D_W'(tx) << UNIT_SH);
  assign ty_u = $signed(D_W'(ty) << UNIT_SH);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      push_data.b[k] = b[k];
      push_data.c[k] = c[k];
      push_data.e[k] = prod_x[k] + prod_y[k];
    end
    push_data.tx = tx;
    push_data.ty = ty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (tri_in.valid) begin
            vx[0] <= {tri_in.v1_x, 1'b0};
            vy[0] <= {tri_in.v1_y, 1'b0};
            vx[1] <= {tri_in.v2_x, 1'b0};
            vy[1] <= {tri_in.v2_y, 1'b0};
            vx[2] <= {tri_in.v3_x, 1'b0};
            vy[2] <= {tri_in.v3_y, 1'b0};
            tx    <= XY_W'(tri_in.tile_col) * XY_W'(TILE_SIZE);
            ty    <= XY_W'(tri_in.tile_row) * XY_W'(TILE_SIZE);
            state <= F_DIFF;
          end
        end
        F_DIFF: begin
          for (int k = 0; k < 3; k++) begin
            b[k]  <= BC_W'(vy[(k + 1) % 3]) - BC_W'(vy[k]);
            c[k]  <= BC_W'(vx[k]) - BC_W'(vx[(k + 1) % 3]);
            dx[k] <= tx_u - D_W'(vx[k]);
            dy[k] <= ty_u - D_W'(vy[k]);
          end
          state <= F_MUL;
        end
        F_MUL: begin
          for (int k = 0; k < 3; k++) begin
            prod_x[k] <= E_W'(dx[k]) * E_W'(b[k]);
            prod_y[k] <= E_W'(dy[k]) * E_W'(c[k]);
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### sv/htr_fifo.sv
// ----------------------------------------------------------------------------
// htr_fifo
// Short queue of triangle setups between the front end and the block walker.
// ----------------------------------------------------------------------------
module htr_fifo import htr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  setup_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output setup_t pop_data
);

  setup_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/htr_back.sv
// ----------------------------------------------------------------------------
// htr_back
// Block walker: one 4x4 block tested per cycle unless stalled; emits covered blocks.
// ----------------------------------------------------------------------------
module htr_back import htr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [DIM_W-1:0] screen_width,
  input  logic [DIM_W-1:0] screen_height,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  setup_t           pop_data,
  htr_out_if.source        blk_out
);

  typedef enum logic [1:0] {B_IDLE, B_RUN, B_FIN} bstate_t;

  bstate_t state;

  logic signed [BC_W-1:0] b_r [3];
  logic signed [BC_W-1:0] c_r [3];
  logic signed [E_W-1:0]  e_row [3];
  logic signed [E_W-1:0]  e_blk [3];
  logic signed [E_W-1:0]  corner [3];
  logic signed [E_W-1:0]  colofs [3][4];
  logic signed [E_W-1:0]  rowofs [3][4];
  logic [XY_W-1:0]        tx_r;
  logic [XY_W-1:0]        ty_r;
  logic [BLK_W-1:0]       bi;
  logic [BLK_W-1:0]       bj;

  // The newest covered block is held back until we know whether it is the last one.
  logic                   pend_valid;
  logic [XY_W-1:0]        pend_x;
  logic [XY_W-1:0]        pend_y;
  logic [COV_W-1:0]       pend_cov;

  logic                   out_valid;
  logic [XY_W-1:0]        out_x;
  logic [XY_W-1:0]        out_y;
  logic [COV_W-1:0]       out_cov;
  logic                   out_last;

  logic [XY_W-1:0]        bx;
  logic [XY_W-1:0]        by;
  logic                   blk_clip;
  logic                   reject;
  logic [COV_W-1:0]       cov;
  logic                   hit;
  logic                   last_blk;
  logic                   out_free;
  logic                   step;
  logic                   out_load;

  assign blk_out.valid    = out_valid;
  assign blk_out.block_x  = out_x;
  assign blk_out.block_y  = out_y;
  assign blk_out.coverage = out_cov;
  assign blk_out.last     = out_last;

  assign pop_ready = (state == B_IDLE);

  always_comb begin
    logic signed [E_W-1:0] dot;
    logic                  pix_ok;
    logic                  pix_in;

    bx       = tx_r + (XY_W'(bi) << 2);
    by       = ty_r + (XY_W'(bj) << 2);
    blk_clip = ({1'b0, bx} >= screen_width) || ({1'b0, by} >= screen_height);

    reject = 1'b0;
    for (int k = 0; k < 3; k++) begin
      dot = e_blk[k] + corner[k];
      if (dot > 0) begin
        reject = 1'b1;
      end
    end

    cov = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        pix_ok = (({1'b0, by} + DIM_W'(r)) < screen_height) &&
                 (({1'b0, bx} + DIM_W'(c)) < screen_width) &&
                 ((4 * int'(bi) + c) < TILE_SIZE) &&
                 ((4 * int'(bj) + r) < TILE_SIZE);
        pix_in = 1'b1;
        for (int k = 0; k < 3; k++) begin
          dot = e_blk[k] + colofs[k][c] + rowofs[k][r];
          if (dot > 0) begin
            pix_in = 1'b0;
          end
        end
        cov[r * 4 + c] = pix_ok && pix_in;
      end
    end

    hit      = !blk_clip && !reject && (cov != '0);
    last_blk = (bi == BLK_W'(BLOCKS_PER_SIDE - 1)) && (bj == BLK_W'(BLOCKS_PER_SIDE - 1));
    out_free = !out_valid || blk_out.ready;
    step     = (state == B_RUN) && (!hit || !pend_valid || out_free);
    out_load = (step && hit && pend_valid) || ((state == B_FIN) && out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      bi         <= '0;
      bj         <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (blk_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop_valid) begin
            for (int k = 0; k < 3; k++) begin
              b_r[k]    <= $signed(pop_data.b[k]);
              c_r[k]    <= $signed(pop_data.c[k]);
              e_row[k]  <= $signed(pop_data.e[k]);
              e_blk[k]  <= $signed(pop_data.e[k]);
              corner[k] <= ($signed(pop_data.b[k]) < 0 ?
                             sx_e($signed(pop_data.b[k])) <<< (UNIT_SH + 2) : '0) +
                           ($signed(pop_data.c[k]) < 0 ?
                             sx_e($signed(pop_data.c[k])) <<< (UNIT_SH + 2) : '0);
              for (int i = 0; i < 4; i++) begin
                colofs[k][i] <= pix_off($signed(pop_data.b[k]), i);
                rowofs[k][i] <= pix_off($signed(pop_data.c[k]), i);
              end
            end
            tx_r  <= pop_data.tx;
            ty_r  <= pop_data.ty;
            bi    <= '0;
            bj    <= '0;
            state <= B_RUN;
          end
        end
        B_RUN: begin
          if (step) begin
            if (hit) begin
              if (pend_valid) begin
                out_x    <= pend_x;
                out_y    <= pend_y;
                out_cov  <= pend_cov;
                out_last <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_x     <= bx;
              pend_y     <= by;
              pend_cov   <= cov;
            end
            if (bi == BLK_W'(BLOCKS_PER_SIDE - 1)) begin
              bi <= '0;
              bj <= bj + 1'b1;
              for (int k = 0; k < 3; k++) begin
                e_row[k] <= e_row[k] + (sx_e(c_r[k]) <<< (UNIT_SH + 2));
                e_blk[k] <= e_row[k] + (sx_e(c_r[k]) <<< (UNIT_SH + 2));
              end
            end else begin
              bi <= bi + 1'b1;
              for (int k = 0; k < 3; k++) begin
                e_blk[k] <= e_blk[k] + (sx_e(b_r[k]) <<< (UNIT_SH + 2));
              end
            end
            if (last_blk) begin
              state <= B_FIN;
            end
          end
        end
        B_FIN: begin
          if (out_free) begin
            out_last <= 1'b1;
            if (pend_valid) begin
              out_x   <= pend_x;
              out_y   <= pend_y;
              out_cov <= pend_cov;
            end else begin
              // Nothing covered: one empty result at the tile origin.
              out_x   <= tx_r;
              out_y   <= ty_r;
              out_cov <= '0;
            end
            pend_valid <= 1'b0;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

### sv/hierarchical_tile_rasterizer_unit.sv
// Flow: triangle setup (states F_IDLE, F_DIFF, F_MUL, F_PUSH), loading the walker, then
// one 4x4 block per cycle while the output does not stall (BLOCKS_PER_SIDE squared, 16
// for a 16x16 tile) and a finishing state. The walker takes a new triangle only when
// done with the last; setup of the next triangle overlaps through a two-entry queue.
// Output back-pressure holds the walker when a second covered block is found.
// Reset (rst, synchronous) empties the queue and sets the screen to 640 x 480.
// ----------------------------------------------------------------------------
// hierarchical_tile_rasterizer_unit
// Edge-function coverage of one triangle over one screen tile, in 4x4 blocks.
// ----------------------------------------------------------------------------
module hierarchical_tile_rasterizer_unit import htr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  htr_cfg_if.sink   cfg,
  htr_in_if.sink    tri_in,
  htr_out_if.source blk_out
);

  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;

  logic   push_valid;
  logic   push_ready;
  setup_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  setup_t pop_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg.data;
        REG_SCREEN_HEIGHT: screen_height <= cfg.data;
        default: ;
      endcase
    end
  end

  htr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .tri_in     (tri_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  htr_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  htr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .blk_out       (blk_out)
  );

endmodule

### tb/htr_tb_pkg.sv
// ----------------------------------------------------------------------------
// htr_tb_pkg
// Transaction types and the coverage scoreboard of the tile rasterizer bench.
// The scoreboard rasterizes each accepted triangle over its tile and queues
// the covered 4x4 blocks that the unit must deliver, in order.
// ----------------------------------------------------------------------------
package htr_tb_pkg;
  import htr_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v3_x;
    logic signed [COORD_W-1:0] v3_y;
    logic [TILE_W-1:0]         tile_col;
    logic [TILE_W-1:0]         tile_row;
  } triangle_t;

  typedef struct {
    logic [XY_W-1:0]  block_x;
    logic [XY_W-1:0]  block_y;
    logic [COV_W-1:0] coverage;
    logic             last;
  } block_t;

  class tile_coverage_check;
    longint screen_w;
    longint screen_h;
    block_t expected_blocks[$];
    int     failures;

    function new();
      screen_w = SCREEN_WIDTH_RST;
      screen_h = SCREEN_HEIGHT_RST;
      failures = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      case (idx)
        REG_SCREEN_WIDTH:  screen_w = val;
        REG_SCREEN_HEIGHT: screen_h = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction

    // Positive means the point lies outside the edge.
    static function longint edge_value(longint ax, longint ay, longint b, longint c,
                                       longint px, longint py);
      return (px - ax) * b + (py - ay) * c;
    endfunction

    // Works out every covered block of one triangle over its tile, in walk order.
    function void add_triangle(triangle_t t);
      longint vx[3];
      longint vy[3];
      longint eb[3];
      longint ec[3];
      longint tx, ty, bx, by, px, py, cx, cy;
      logic [COV_W-1:0] cov;
      bit     rejected, pix_in, have_prev;
      int     emitted;
      block_t prev, cur;
      vx[0] = 2 * longint'(t.v1_x);
      vy[0] = 2 * longint'(t.v1_y);
      vx[1] = 2 * longint'(t.v2_x);
      vy[1] = 2 * longint'(t.v2_y);
      vx[2] = 2 * longint'(t.v3_x);
      vy[2] = 2 * longint'(t.v3_y);
      for (int k = 0; k < 3; k++) begin
        eb[k] = vy[(k + 1) % 3] - vy[k];
        ec[k] = vx[k] - vx[(k + 1) % 3];
      end
      tx = longint'(t.tile_col) * TILE_SIZE;
      ty = longint'(t.tile_row) * TILE_SIZE;
      emitted   = 0;
      have_prev = 1'b0;
      for (int bj = 0; bj < BLOCKS_PER_SIDE; bj++) begin
        for (int bi = 0; bi < BLOCKS_PER_SIDE; bi++) begin
          bx = tx + 4 * bi;
          by = ty + 4 * bj;
          if (bx >= screen_w || by >= screen_h) continue;
          // Each edge is tested at the block corner that lies furthest inside it.
          rejected = 1'b0;
          for (int k = 0; k < 3; k++) begin
            cx = (bx + ((eb[k] < 0) ? 4 : 0)) * UNIT;
            cy = (by + ((ec[k] < 0) ? 4 : 0)) * UNIT;
            if (edge_value(vx[k], vy[k], eb[k], ec[k], cx, cy) > 0) rejected = 1'b1;
          end
          if (rejected) continue;
          cov = '0;
          for (int r = 0; r < 4; r++) begin
            py = by + r;
            if (py >= screen_h || 4 * bj + r >= TILE_SIZE) continue;
            for (int col = 0; col < 4; col++) begin
              px = bx + col;
              if (px >= screen_w || 4 * bi + col >= TILE_SIZE) continue;
              cx = px * UNIT + UNIT / 2;
              cy = py * UNIT + UNIT / 2;
              pix_in = 1'b1;
              for (int k = 0; k < 3; k++) begin
                if (edge_value(vx[k], vy[k], eb[k], ec[k], cx, cy) > 0) pix_in = 1'b0;
              end
              if (pix_in) cov[r * 4 + col] = 1'b1;
            end
          end
          if (cov != '0 && emitted < 16) begin
            cur.block_x  = bx[XY_W-1:0];
            cur.block_y  = by[XY_W-1:0];
            cur.coverage = cov;
            cur.last     = 1'b0;
            if (have_prev) expected_blocks.push_back(prev);
            prev      = cur;
            have_prev = 1'b1;
            emitted++;
          end
        end
      end
      // An empty tile still closes with one result at the tile origin.
      if (!have_prev) begin
        prev.block_x  = tx[XY_W-1:0];
        prev.block_y  = ty[XY_W-1:0];
        prev.coverage = '0;
      end
      prev.last = 1'b1;
      expected_blocks.push_back(prev);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        failures++;
      end
    endfunction

    function void check_block(block_t got);
      block_t want;
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected block, expected none, got x=%0d y=%0d cov=0x%h last=%0b",
                 $time, got.block_x, got.block_y, got.coverage, got.last);
        failures++;
        return;
      end
      want = expected_blocks.pop_front();
      compare_field("block_x", want.block_x, got.block_x);
      compare_field("block_y", want.block_y, got.block_y);
      compare_field("coverage", want.coverage, got.coverage);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

endpackage

### tb/hierarchical_tile_rasterizer_unit_tb.sv
// ----------------------------------------------------------------------------
// hierarchical_tile_rasterizer_unit_tb
// Drives triangles and tiles into the rasterizer under several screen sizes,
// with random gaps and back-pressure, and checks every covered block result
// against the scoreboard's own rasterization of the same triangle.
// ----------------------------------------------------------------------------
module hierarchical_tile_rasterizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htr_pkg::*;
  import htr_tb_pkg::*;

  localparam int LIMIT_CYCLES    = 1000000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int BIG             = 32640;  // 2040 pixels in 12.4 fixed point

  logic clk = 1'b0;
  logic rst = 1'b1;

  htr_in_if  tri_if();
  htr_out_if blk_if();
  htr_cfg_if cfg_if();

  tile_coverage_check sb;
  bit steady;
  bit hold_off_req;
  int cycle_count;

  hierarchical_tile_rasterizer_unit u_top (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_if),
    .tri_in(tri_if),
    .blk_out(blk_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic triangle_t make_tri(int x1, int y1, int x2, int y2, int x3, int y3,
                                         int col, int row);
    triangle_t t;
    t.v1_x     = COORD_W'(x1);
    t.v1_y     = COORD_W'(y1);
    t.v2_x     = COORD_W'(x2);
    t.v2_y     = COORD_W'(y2);
    t.v3_x     = COORD_W'(x3);
    t.v3_y     = COORD_W'(y3);
    t.tile_col = TILE_W'(col);
    t.tile_row = TILE_W'(row);
    return t;
  endfunction

  // All driving tasks start and end at a falling edge.
  task automatic send_triangle(triangle_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      tri_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    tri_if.v1_x     = t.v1_x;
    tri_if.v1_y     = t.v1_y;
    tri_if.v2_x     = t.v2_x;
    tri_if.v2_y     = t.v2_y;
    tri_if.v3_x     = t.v3_x;
    tri_if.v3_y     = t.v3_y;
    tri_if.tile_col = t.tile_col;
    tri_if.tile_row = t.tile_row;
    tri_if.valid    = 1'b1;
    do @(posedge clk); while (!tri_if.ready);
    sb.add_triangle(t);
    @(negedge clk);
  endtask

  task automatic set_screen(int w, int h);
    cfg_if.index = REG_SCREEN_WIDTH;
    cfg_if.data  = DIM_W'(w);
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_reg(REG_SCREEN_WIDTH, DIM_W'(w));
    @(negedge clk);
    cfg_if.index = REG_SCREEN_HEIGHT;
    cfg_if.data  = DIM_W'(h);
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_reg(REG_SCREEN_HEIGHT, DIM_W'(h));
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    tri_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly triangles placed around the chosen tile, some with the wrong winding,
  // some collapsed to a point, and a share of fully random transactions.
  task automatic run_random(int count, int max_tile);
    triangle_t t;
    int kind, col, row, spread, tmp;
    int px[3];
    int py[3];
    longint area;
    for (int n = 0; n < count; n++) begin
      kind   = $urandom_range(0, 99);
      col    = $urandom_range(0, max_tile);
      row    = $urandom_range(0, max_tile);
      spread = ($urandom_range(0, 2) == 0) ? 200 : 24;
      for (int i = 0; i < 3; i++) begin
        px[i] = (col * 16 + int'($urandom_range(0, 2 * spread + 16)) - spread) * 16
                + int'($urandom_range(0, 15));
        py[i] = (row * 16 + int'($urandom_range(0, 2 * spread + 16)) - spread) * 16
                + int'($urandom_range(0, 15));
      end
      if (kind < 5) begin
        px[1] = px[0];
        px[2] = px[0];
        py[1] = py[0];
        py[2] = py[0];
      end
      area = longint'(px[2] - px[0]) * (py[1] - py[0])
             + longint'(py[2] - py[0]) * (px[0] - px[1]);
      if (area > 0 && kind >= 20) begin
        tmp   = px[1];
        px[1] = px[2];
        px[2] = tmp;
        tmp   = py[1];
        py[1] = py[2];
        py[2] = tmp;
      end
      t = make_tri(px[0], py[0], px[1], py[1], px[2], py[2], col, row);
      if (kind >= 90) begin
        t = make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom_range(0, 255), $urandom_range(0, 255));
      end
      send_triangle(t);
    end
  endtask

  // Result side: random ready gaps, plus one long hold-off on request.
  initial begin : out_ready_gen
    int lo, hi;
    blk_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        lo = HOLD_OFF_CYCLES;
      end else begin
        lo = pick_gap();
      end
      if (lo > 0) begin
        blk_if.ready = 1'b0;
        repeat (lo) @(negedge clk);
      end
      blk_if.ready = 1'b1;
      hi = $urandom_range(1, 12);
      repeat (hi) @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_mon
    block_t got;
    if (!rst && blk_if.valid && blk_if.ready) begin
      got.block_x  = blk_if.block_x;
      got.block_y  = blk_if.block_y;
      got.coverage = blk_if.coverage;
      got.last     = blk_if.last;
      sb.check_block(got);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("hierarchical_tile_rasterizer_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    sb           = new();
    steady       = 1'b0;
    hold_off_req = 1'b0;
    tri_if.valid    = 1'b0;
    tri_if.v1_x     = '0;
    tri_if.v1_y     = '0;
    tri_if.v2_x     = '0;
    tri_if.v2_y     = '0;
    tri_if.v3_x     = '0;
    tri_if.v3_y     = '0;
    tri_if.tile_col = '0;
    tri_if.tile_row = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_SCREEN_WIDTH;
    cfg_if.data     = '0;
    rst = 1'b1;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed cases on the reset screen of 640 x 480.
    send_triangle(make_tri(BIG, -BIG, BIG, BIG, -BIG, BIG, 0, 0));
    send_triangle(make_tri(BIG, -BIG, -BIG, BIG, BIG, BIG, 0, 0));
    send_triangle(make_tri(84, 120, 84, 120, 84, 120, 0, 0));
    send_triangle(make_tri(84, 120, 84, 120, 84, 120, 255, 255));
    send_triangle(make_tri(-32768, -32768, 32767, -32768, 32767, 32767, 0, 0));
    send_triangle(make_tri(-32768, -32768, 32767, 32767, 32767, -32768, 0, 0));
    // Edges run exactly through pixel centers, which count as inside.
    send_triangle(make_tri(8, 8, 136, 8, 8, 136, 0, 0));
    send_triangle(make_tri(56, 56, 57, 56, 56, 57, 0, 0));
    // Collinear vertices leave only the pixels on the line.
    send_triangle(make_tri(0, 0, 256, 256, 512, 512, 0, 0));
    send_triangle(make_tri(0, 0, 256, 256, 512, 512, 1, 1));
    send_triangle(make_tri(224, 224, 288, 224, 224, 288, 1, 1));
    send_triangle(make_tri(224, 224, 288, 224, 224, 288, 0, 0));
    send_triangle(make_tri(BIG, -BIG, BIG, BIG, -BIG, BIG, 39, 29));
    send_triangle(make_tri(BIG, -BIG, BIG, BIG, -BIG, BIG, 40, 0));
    send_triangle(make_tri(BIG, -BIG, BIG, BIG, -BIG, BIG, 0, 30));
    send_triangle(make_tri(32767, 32767, 32767, 32767, 32767, 32767, 127, 127));
    wait_drained();

    set_screen(4096, 4096);
    steady = 1'b1;
    run_random(20, 100);
    steady = 1'b0;
    wait_drained();

    set_screen(8191, 8191);
    send_triangle(make_tri(84, 120, 84, 120, 84, 120, 255, 255));
    send_triangle(make_tri(-32768, -32768, 32767, -32768, 32767, 32767, 127, 0));
    send_triangle(make_tri(-32768, -32768, 32767, -32768, 32767, 32767, 127, 127));
    run_random(15, 100);
    wait_drained();

    // A zero width or height clips everything.
    set_screen(0, 8191);
    send_triangle(make_tri(BIG, -BIG, BIG, BIG, -BIG, BIG, 0, 0));
    run_random(4, 4);
    wait_drained();

    set_screen(8191, 0);
    send_triangle(make_tri(BIG, -BIG, BIG, BIG, -BIG, BIG, 0, 0));
    run_random(3, 4);
    wait_drained();

    set_screen(1, 1);
    send_triangle(make_tri(BIG, -BIG, BIG, BIG, -BIG, BIG, 0, 0));
    run_random(10, 2);
    wait_drained();

    set_screen(17, 23);
    send_triangle(make_tri(BIG, -BIG, BIG, BIG, -BIG, BIG, 1, 1));
    run_random(20, 2);
    wait_drained();

    // The result side holds off while triangles keep coming, so the unit backs up.
    set_screen($urandom_range(1, 4096), $urandom_range(1, 4096));
    hold_off_req = 1'b1;
    run_random(25, 30);
    wait_drained();

    set_screen(640, 480);
    run_random(5, 40);
    wait_drained();

    repeat (40) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("hierarchical_tile_rasterizer_unit regression: pass");
    end else begin
      $display("hierarchical_tile_rasterizer_unit regression: fail");
    end
    $finish;
  end

endmodule
